/* design/ssoe_pkg.sv */
// ----------------------------------------------------------------------------
// Small set operations engine package
// Shared sizes, opcodes and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package ssoe_pkg;

  // Number of entries that each list holds.
  localparam int Capacity = 16;
  // Width of a fill count or an index that must also hold Capacity itself.
  localparam int CntW     = $clog2(Capacity + 1);
  // Width of a memory address.
  localparam int AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int ValW     = 32;
  localparam int OpW      = 4;
  // Width of the count fields on the result stream.
  localparam int CountW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR    = 4'd0,
    OP_APPEND_A = 4'd1,
    OP_APPEND_B = 4'd2,
    OP_UNION    = 4'd3,
    OP_INTER    = 4'd4,
    OP_A_MINUS  = 4'd5,
    OP_B_MINUS  = 4'd6,
    OP_COUNT    = 4'd7,
    OP_MEMBER   = 4'd8
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;             // request accepted: latch value, run clear/append
    logic start_pass;       // set up a pass over the source list
    logic pass_src_b;       // source is list B, the other list is A
    logic pass_other_none;  // the other list counts as empty
    logic pass_keep_in;     // keep sources found in the other list
    logic cand_take;        // latch the fetched source entry, step the index
    logic scan_init;        // restart the scan of the other list
    logic scan_step;        // advance the scan of the other list
    logic rec_fa;           // record scan hit as found in A
    logic rec_fb;           // record scan hit as found in B
    logic pend_take;        // park the candidate as pending element
    logic push_elem;        // load the pending element into the output
    logic push_last;        // the pushed element closes the result
    logic push_stat;        // load a status item into the output
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic src_done;   // every source entry has been fetched
    logic scan_done;  // the scan of the other list has finished
    logic keep;       // the current candidate belongs to the result
    logic pend_v;     // an element is pending
    logic out_free;   // the output register can take an item this cycle
  } sts_t;

endpackage

/* design/small_set_operations_engine_top.sv */
// ----------------------------------------------------------------------------
// Small set operations engine
// Keeps two bounded lists of signed 32-bit values and answers set queries.
// ----------------------------------------------------------------------------
// One request enters on the s_axis channel: an opcode and a value. It clears
// both lists, appends the value to list A or B, or runs union, intersection,
// A minus B, B minus A, cardinality or membership. Results leave on m_axis,
// one element per transfer, with tlast on the final one; a request that
// yields no element gives one transfer with tuser (empty) set.
// The block works on one request at a time; s_axis_tready is high only while
// it waits for a request, but it may take the next request while the final
// result of the previous one still sits in the output register.
// Clear, append, cardinality and unknown opcodes go straight to their status
// result; membership scans list A, then list B. A list pass compares every
// source entry against the other list, one entry a cycle through the single
// read port of that list's memory (the first union pass treats the other
// list as empty).
// Reset empties both lists (fill counts go to zero). When the receiver
// stalls, the engine holds its work until the output register frees up.
// ----------------------------------------------------------------------------
module small_set_operations_engine_top
  import ssoe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] opcode, [35:4] item_value, [39:36] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] result_value, [32] found_in_a, [33] found_in_b, [38:34] count_a,
  // [43:39] count_b, [44] overflow, [47:45] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] empty_res
  output logic [0:0]  m_axis_tuser
);

  cmd_t cmd;
  sts_t sts;

  logic signed [ValW-1:0] res_value;
  logic                   res_fa, res_fb, res_ovf, res_empty;
  logic [CountW-1:0]      res_cnta, res_cntb;

  // The controller sequences the request; the datapath owns all list storage.
  ssoe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_opcode_i (s_axis_tdata[3:0]),
    .sts_i      (sts),
    .s_ready_o  (s_axis_tready),
    .cmd_o      (cmd)
  );

  ssoe_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_opcode_i   (s_axis_tdata[3:0]),
    .s_value_i    (s_axis_tdata[35:4]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .m_ready_i    (m_axis_tready),
    .m_valid_o    (m_axis_tvalid),
    .m_value_o    (res_value),
    .m_last_o     (m_axis_tlast),
    .m_empty_o    (res_empty),
    .m_found_a_o  (res_fa),
    .m_found_b_o  (res_fb),
    .m_count_a_o  (res_cnta),
    .m_count_b_o  (res_cntb),
    .m_overflow_o (res_ovf)
  );

  assign m_axis_tdata = {3'b000, res_ovf, res_cntb, res_cnta, res_fb, res_fa, res_value};
  assign m_axis_tuser = res_empty;

  // Every opcode leaves the idle state, so ready drops right after a request.
  a_ready_drops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted twice in a row");

  // Fill counts never pass the list capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_cnta <= CountW'(Capacity)) && (res_cntb <= CountW'(Capacity)))
    else $error("list count beyond capacity");

  // An element item carries no membership or overflow flags.
  a_elem_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> !res_fa && !res_fb && !res_ovf)
    else $error("status flags on an element item");

  // An empty item always closes its result.
  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (res_value == '0))
    else $error("empty item not final or not zero");

endmodule

/* design/ssoe_ctrl.sv */
// ----------------------------------------------------------------------------
// Small set operations engine controller
// One-hot state machine that sequences requests, list passes and scans.
// ----------------------------------------------------------------------------
module ssoe_ctrl
  import ssoe_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  input  logic [OpW-1:0] s_opcode_i,
  input  sts_t           sts_i,
  output logic           s_ready_o,
  output cmd_t           cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_STAT  = 9'b000000010,
    ST_MA    = 9'b000000100,
    ST_MB    = 9'b000001000,
    ST_PRD   = 9'b000010000,
    ST_PCAND = 9'b000100000,
    ST_PSCAN = 9'b001000000,
    ST_PDEC  = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   union_more_q, union_more_d;

  always_comb begin
    state_d      = state_q;
    union_more_d = union_more_q;
    cmd_o        = '0;
    s_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (op_e'(s_opcode_i))
            OP_UNION: begin
              cmd_o.start_pass      = 1'b1;
              cmd_o.pass_other_none = 1'b1;
              union_more_d          = 1'b1;
              state_d               = ST_PRD;
            end
            OP_INTER: begin
              cmd_o.start_pass   = 1'b1;
              cmd_o.pass_keep_in = 1'b1;
              state_d            = ST_PRD;
            end
            OP_A_MINUS: begin
              cmd_o.start_pass = 1'b1;
              state_d          = ST_PRD;
            end
            OP_B_MINUS: begin
              cmd_o.start_pass = 1'b1;
              cmd_o.pass_src_b = 1'b1;
              state_d          = ST_PRD;
            end
            OP_MEMBER: begin
              // Scan A first: A is the other list when B is the source.
              cmd_o.start_pass = 1'b1;
              cmd_o.pass_src_b = 1'b1;
              cmd_o.scan_init  = 1'b1;
              state_d          = ST_MA;
            end
            default: begin
              state_d = ST_STAT;
            end
          endcase
        end
      end
      ST_MA: begin
        if (sts_i.scan_done) begin
          cmd_o.rec_fa     = 1'b1;
          cmd_o.start_pass = 1'b1;
          cmd_o.scan_init  = 1'b1;
          state_d          = ST_MB;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_MB: begin
        if (sts_i.scan_done) begin
          cmd_o.rec_fb = 1'b1;
          state_d      = ST_STAT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.push_stat = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_PRD: begin
        if (sts_i.src_done) begin
          if (union_more_q) begin
            // Second union pass: entries of B that are not in A.
            cmd_o.start_pass = 1'b1;
            cmd_o.pass_src_b = 1'b1;
            union_more_d     = 1'b0;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          state_d = ST_PCAND;
        end
      end
      ST_PCAND: begin
        cmd_o.cand_take = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = ST_PSCAN;
      end
      ST_PSCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_PDEC;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_PDEC: begin
        if (!sts_i.keep) begin
          state_d = ST_PRD;
        end else if (!sts_i.pend_v) begin
          cmd_o.pend_take = 1'b1;
          state_d         = ST_PRD;
        end else if (sts_i.out_free) begin
          cmd_o.push_elem = 1'b1;
          cmd_o.pend_take = 1'b1;
          state_d         = ST_PRD;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          if (sts_i.pend_v) begin
            cmd_o.push_elem = 1'b1;
            cmd_o.push_last = 1'b1;
          end else begin
            cmd_o.push_stat = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      union_more_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      union_more_q <= union_more_d;
    end
  end

endmodule

/* design/ssoe_dpath.sv */
// ----------------------------------------------------------------------------
// Small set operations engine datapath
// List memories, fill counts, scan counters, comparator and output register.
// ----------------------------------------------------------------------------
module ssoe_dpath
  import ssoe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [OpW-1:0]           s_opcode_i,
  input  logic signed [ValW-1:0]   s_value_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic                     m_ready_i,
  output logic                     m_valid_o,
  output logic signed [ValW-1:0]   m_value_o,
  output logic                     m_last_o,
  output logic                     m_empty_o,
  output logic                     m_found_a_o,
  output logic                     m_found_b_o,
  output logic [CountW-1:0]        m_count_a_o,
  output logic [CountW-1:0]        m_count_b_o,
  output logic                     m_overflow_o
);

  logic [ValW-1:0] mem_a [Capacity];
  logic [ValW-1:0] mem_b [Capacity];
  logic [ValW-1:0] rd_a_q, rd_b_q;

  logic [CntW-1:0] fill_a_q, fill_b_q;
  logic [CntW-1:0] i_q, j_q;
  logic            cmp_v_q, hit_q;
  logic            src_b_q, other_none_q, keep_in_q;
  logic            found_a_q, found_b_q, ovf_q;
  logic [ValW-1:0] cand_q, pend_q;
  logic            pend_v_q;

  logic            o_valid_q, o_last_q, o_empty_q, o_fa_q, o_fb_q, o_ovf_q;
  logic [ValW-1:0] o_value_q;
  logic [CountW-1:0] o_cnta_q, o_cntb_q;

  logic [CntW-1:0] n_src, n_other;
  logic [ValW-1:0] rd_src, rd_other;
  logic [AddrW-1:0] addr_a, addr_b;
  logic            wr_a, wr_b, full_a, full_b;
  logic            out_free;
  op_e             op;

  assign op       = op_e'(s_opcode_i);
  assign full_a   = (fill_a_q >= CntW'(Capacity));
  assign full_b   = (fill_b_q >= CntW'(Capacity));
  assign wr_a     = cmd_i.load && (op == OP_APPEND_A) && !full_a;
  assign wr_b     = cmd_i.load && (op == OP_APPEND_B) && !full_b;

  // The source list is read at the pass index, the other list at the scan index.
  assign n_src    = src_b_q ? fill_b_q : fill_a_q;
  assign n_other  = other_none_q ? '0 : (src_b_q ? fill_a_q : fill_b_q);
  assign rd_src   = src_b_q ? rd_b_q : rd_a_q;
  assign rd_other = src_b_q ? rd_a_q : rd_b_q;
  assign addr_a   = src_b_q ? j_q[AddrW-1:0] : i_q[AddrW-1:0];
  assign addr_b   = src_b_q ? i_q[AddrW-1:0] : j_q[AddrW-1:0];
  assign out_free = !o_valid_q || m_ready_i;

  assign sts_o.src_done  = (i_q >= n_src);
  assign sts_o.scan_done = (j_q >= n_other) && !cmp_v_q;
  assign sts_o.keep      = (hit_q == keep_in_q);
  assign sts_o.pend_v    = pend_v_q;
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[fill_a_q[AddrW-1:0]] <= s_value_i;
    end
    if (wr_b) begin
      mem_b[fill_b_q[AddrW-1:0]] <= s_value_i;
    end
    rd_a_q <= mem_a[addr_a];
    rd_b_q <= mem_b[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_a_q     <= '0;
      fill_b_q     <= '0;
      i_q          <= '0;
      j_q          <= '0;
      cmp_v_q      <= 1'b0;
      hit_q        <= 1'b0;
      src_b_q      <= 1'b0;
      other_none_q <= 1'b0;
      keep_in_q    <= 1'b0;
      found_a_q    <= 1'b0;
      found_b_q    <= 1'b0;
      ovf_q        <= 1'b0;
      pend_v_q     <= 1'b0;
      o_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        found_a_q <= 1'b0;
        found_b_q <= 1'b0;
        pend_v_q  <= 1'b0;
        ovf_q     <= ((op == OP_APPEND_A) && full_a) || ((op == OP_APPEND_B) && full_b);
        if (op == OP_CLEAR) begin
          fill_a_q <= '0;
          fill_b_q <= '0;
        end
        if (wr_a) begin
          fill_a_q <= fill_a_q + 1'b1;
        end
        if (wr_b) begin
          fill_b_q <= fill_b_q + 1'b1;
        end
      end
      if (cmd_i.start_pass) begin
        i_q          <= '0;
        src_b_q      <= cmd_i.pass_src_b;
        other_none_q <= cmd_i.pass_other_none;
        keep_in_q    <= cmd_i.pass_keep_in;
      end
      if (cmd_i.cand_take) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        j_q     <= '0;
        cmp_v_q <= 1'b0;
        hit_q   <= 1'b0;
      end else if (cmd_i.scan_step) begin
        // Address goes out one cycle, its data is compared the next.
        if (j_q < n_other) begin
          j_q     <= j_q + 1'b1;
          cmp_v_q <= 1'b1;
        end else begin
          cmp_v_q <= 1'b0;
        end
        if (cmp_v_q && (rd_other == cand_q)) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.rec_fa) begin
        found_a_q <= hit_q;
      end
      if (cmd_i.rec_fb) begin
        found_b_q <= hit_q;
      end
      if (cmd_i.pend_take) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.push_elem) begin
        pend_v_q <= 1'b0;
      end
      if (cmd_i.push_elem || cmd_i.push_stat) begin
        o_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cand_q <= s_value_i;
    end else if (cmd_i.cand_take) begin
      cand_q <= rd_src;
    end
    if (cmd_i.pend_take) begin
      pend_q <= cand_q;
    end
    if (cmd_i.push_elem || cmd_i.push_stat) begin
      o_value_q <= cmd_i.push_elem ? pend_q : '0;
      o_last_q  <= cmd_i.push_stat || cmd_i.push_last;
      o_empty_q <= cmd_i.push_stat;
      o_fa_q    <= cmd_i.push_stat && found_a_q;
      o_fb_q    <= cmd_i.push_stat && found_b_q;
      o_ovf_q   <= cmd_i.push_stat && ovf_q;
      o_cnta_q  <= CountW'(fill_a_q);
      o_cntb_q  <= CountW'(fill_b_q);
    end
  end

  assign m_valid_o    = o_valid_q;
  assign m_value_o    = o_value_q;
  assign m_last_o     = o_last_q;
  assign m_empty_o    = o_empty_q;
  assign m_found_a_o  = o_fa_q;
  assign m_found_b_o  = o_fb_q;
  assign m_count_a_o  = o_cnta_q;
  assign m_count_b_o  = o_cntb_q;
  assign m_overflow_o = o_ovf_q;

endmodule

/* tb/sv/small_set_operations_engine_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small set operations engine testbench
// Drives list appends, clears and set queries into the engine. A behavioral
// copy of both lists predicts every result transfer, and each one is checked
// field by field as it leaves the block.
// ----------------------------------------------------------------------------
module small_set_operations_engine_top_tb;
  import ssoe_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int DirectedLen = 25;
  localparam int RandomLen   = 225;
  localparam int TailCycles  = 40;
  localparam int MaxReports  = 20;

  // Opcodes that the engine does not define; they change neither list and give one status transfer.
  localparam logic [OpW-1:0] OpSpareLo = 4'd9;
  localparam logic [OpW-1:0] OpSpareHi = 4'd15;

  // One request as the sender presents it. A set drain flag holds the
  // request back until every earlier result has been received.
  typedef struct {
    logic [OpW-1:0] op;
    logic [ValW-1:0] val;
    bit              drain;
  } set_req_t;

  // One result transfer, split into its fields.
  typedef struct packed {
    logic [ValW-1:0]   value;
    logic              last;
    logic              empty;
    logic              in_a;
    logic              in_b;
    logic [CountW-1:0] cnt_a;
    logic [CountW-1:0] cnt_b;
    logic              ovf;
  } set_res_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  small_set_operations_engine_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the engine's lists.
  logic [ValW-1:0] shadow_a [Capacity];
  logic [ValW-1:0] shadow_b [Capacity];
  int              fill_a = 0;
  int              fill_b = 0;

  set_req_t req_queue [$];
  set_res_t expected_results [$];

  int n_total      = 0;
  int n_accepted   = 0;
  int pred_total   = 0;  // results predicted so far, written by the driver
  int seen_total   = 0;  // results received so far, written by the monitor
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int rx_stall_pct = 0;

  // Driver scratch.
  bit hold;
  bit go;
  int phase;
  int tx_idle_pct;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic bit holds_value(input logic [ValW-1:0] lst [Capacity],
                                     input int n, input logic [ValW-1:0] v);
    for (int i = 0; i < n; i++)
      if (lst[AddrW'(i)] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_result(input logic [ValW-1:0] value, input bit empty,
                                      input bit in_a, input bit in_b, input bit ovf,
                                      input bit last);
    set_res_t r;
    r.value = value;
    r.last  = last;
    r.empty = empty;
    r.in_a  = in_a;
    r.in_b  = in_b;
    r.cnt_a = CountW'(fill_a);
    r.cnt_b = CountW'(fill_b);
    r.ovf   = ovf;
    expected_results.push_back(r);
    pred_total++;
  endfunction

  // Applies one request to the shadow lists and queues the transfers it yields.
  task automatic predict_request(input logic [OpW-1:0] op, input logic [ValW-1:0] val);
    logic [ValW-1:0] elems [$];
    bit in_a;
    bit in_b;
    bit ovf;
    in_a = 1'b0;
    in_b = 1'b0;
    ovf  = 1'b0;
    case (op)
      OP_CLEAR: begin
        fill_a = 0;
        fill_b = 0;
      end
      OP_APPEND_A: begin
        if (fill_a < Capacity) begin
          shadow_a[AddrW'(fill_a)] = val;
          fill_a++;
        end else begin
          ovf = 1'b1;
        end
      end
      OP_APPEND_B: begin
        if (fill_b < Capacity) begin
          shadow_b[AddrW'(fill_b)] = val;
          fill_b++;
        end else begin
          ovf = 1'b1;
        end
      end
      OP_UNION: begin
        for (int i = 0; i < fill_a; i++) elems.push_back(shadow_a[AddrW'(i)]);
        for (int i = 0; i < fill_b; i++)
          if (!holds_value(shadow_a, fill_a, shadow_b[AddrW'(i)]))
            elems.push_back(shadow_b[AddrW'(i)]);
      end
      OP_INTER: begin
        for (int i = 0; i < fill_a; i++)
          if (holds_value(shadow_b, fill_b, shadow_a[AddrW'(i)]))
            elems.push_back(shadow_a[AddrW'(i)]);
      end
      OP_A_MINUS: begin
        for (int i = 0; i < fill_a; i++)
          if (!holds_value(shadow_b, fill_b, shadow_a[AddrW'(i)]))
            elems.push_back(shadow_a[AddrW'(i)]);
      end
      OP_B_MINUS: begin
        for (int i = 0; i < fill_b; i++)
          if (!holds_value(shadow_a, fill_a, shadow_b[AddrW'(i)]))
            elems.push_back(shadow_b[AddrW'(i)]);
      end
      OP_MEMBER: begin
        in_a = holds_value(shadow_a, fill_a, val);
        in_b = holds_value(shadow_b, fill_b, val);
      end
      default: ;
    endcase
    // Status requests and queries with nothing to report give one empty transfer.
    if (elems.size() == 0) begin
      push_result('0, 1'b1, in_a, in_b, ovf, 1'b1);
    end else begin
      foreach (elems[i]) push_result(elems[i], 1'b0, 1'b0, 1'b0, 1'b0,
                                     i == elems.size() - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic void add_req(input logic [OpW-1:0] op, input logic [ValW-1:0] val,
                                  input bit drain = 1'b0);
    set_req_t r;
    r.op    = op;
    r.val   = val;
    r.drain = drain;
    req_queue.push_back(r);
  endfunction

  function automatic logic [ValW-1:0] pool_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // A well-formed sequence: usually a clear, then appends to both lists with
  // values drawn from a small pool so that repeats and overlaps are common,
  // then a few queries. Now and then the lists are pushed past full.
  function automatic void add_list_sequence();
    logic [ValW-1:0] pool [6];
    int na;
    int nb;
    int nq;
    bit big;
    foreach (pool[i]) pool[i] = pool_value();
    big = ($urandom_range(0, 99) < 15);
    na  = big ? $urandom_range(14, 18) : $urandom_range(0, 6);
    nb  = big ? $urandom_range(14, 18) : $urandom_range(0, 6);
    nq  = $urandom_range(1, 4);
    if ($urandom_range(0, 99) < 80) add_req(OP_CLEAR, $urandom());
    while (na > 0 || nb > 0) begin
      if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 0)) begin
        add_req(OP_APPEND_A, pool[3'($urandom_range(0, 5))]);
        na--;
      end else begin
        add_req(OP_APPEND_B, pool[3'($urandom_range(0, 5))]);
        nb--;
      end
    end
    repeat (nq) begin
      if ($urandom_range(0, 99) < 70)
        add_req(OpW'($urandom_range(int'(OP_UNION), int'(OP_MEMBER))),
                pool[3'($urandom_range(0, 5))]);
      else
        add_req(OpW'($urandom_range(int'(OP_UNION), int'(OP_MEMBER))), $urandom());
    end
  endfunction

  function automatic void build_stimulus();
    // Empty lists: every query must return a single empty transfer.
    add_req(OP_CLEAR, 32'h0);
    add_req(OP_UNION, 32'h0);
    add_req(OP_INTER, 32'h0);
    add_req(OP_A_MINUS, 32'h0);
    add_req(OP_B_MINUS, 32'h0);
    add_req(OP_MEMBER, 32'h0);
    // Extreme values, with a duplicate in list B.
    add_req(OP_APPEND_A, 32'h8000_0000);
    add_req(OP_APPEND_A, 32'h7fff_ffff);
    add_req(OP_APPEND_A, 32'h0000_0000);
    add_req(OP_APPEND_A, 32'hffff_ffff);
    add_req(OP_APPEND_B, 32'h7fff_ffff);
    add_req(OP_APPEND_B, 32'h0000_0005);
    add_req(OP_APPEND_B, 32'hffff_ffff);
    add_req(OP_APPEND_B, 32'hffff_ffff);
    add_req(OP_UNION, 32'h0);
    add_req(OP_INTER, 32'h0);
    add_req(OP_A_MINUS, 32'h0);
    add_req(OP_B_MINUS, 32'h0);
    add_req(OP_COUNT, 32'hffff_ffff);
    add_req(OP_MEMBER, 32'h7fff_ffff);
    add_req(OP_MEMBER, 32'h0000_0005);
    add_req(OP_MEMBER, 32'h8000_0000);
    add_req(OP_MEMBER, 32'h1234_5678);
    // Unused opcodes change neither list and give one status transfer.
    add_req(OpSpareLo, 32'hffff_ffff);
    add_req(OpSpareHi, 32'h0);

    // The first random request waits until the engine has fully drained.
    add_req(OP_COUNT, $urandom(), 1'b1);
    while (req_queue.size() < DirectedLen + RandomLen) begin
      if ($urandom_range(0, 99) < 75) begin
        add_list_sequence();
      end else begin
        repeat ($urandom_range(1, 6)) add_req(OpW'($urandom_range(0, 15)), $urandom(),
                                             $urandom_range(0, 99) < 3);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the head of the request queue. The run is split into
  // four quarters by accepted requests: no idling, sender idling, receiver
  // stalling, and both together.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      hold = s_axis_tvalid && !s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(req_queue[0].op, req_queue[0].val);
        void'(req_queue.pop_front());
        n_accepted++;
      end
      phase = (n_total > 0) ? (n_accepted * 4) / n_total : 0;
      if (phase > 3) phase = 3;
      tx_idle_pct   = (phase == 1) ? 63 : (phase == 3) ? 34 : 0;
      rx_stall_pct <= (phase == 2) ? 63 : (phase == 3) ? 34 : 0;
      // A request on the bus stays there until it is taken.
      if (!hold) begin
        go = (req_queue.size() > 0);
        if (go && req_queue[0].drain && pred_total != seen_total) go = 1'b0;
        if (go && tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) go = 1'b0;
        s_axis_tvalid <= go;
        if (go) s_axis_tdata <= {4'b0, req_queue[0].val, req_queue[0].op};
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted transfer is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [ValW-1:0] exp_v,
                                      input logic [ValW-1:0] act_v);
    if (exp_v !== act_v) begin
      if (err_cnt < MaxReports)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  set_res_t act_res;
  set_res_t exp_res;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_res.value = m_axis_tdata[31:0];
      act_res.in_a  = m_axis_tdata[32];
      act_res.in_b  = m_axis_tdata[33];
      act_res.cnt_a = m_axis_tdata[38:34];
      act_res.cnt_b = m_axis_tdata[43:39];
      act_res.ovf   = m_axis_tdata[44];
      act_res.last  = m_axis_tlast;
      act_res.empty = m_axis_tuser[0];
      seen_total   <= seen_total + 1;
      if (expected_results.size() == 0) begin
        if (err_cnt < MaxReports)
          $display("%0t: unexpected result, expected none, actual %h", $time, act_res);
        err_cnt++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("result_value", exp_res.value, act_res.value);
        check_field("last", ValW'(exp_res.last), ValW'(act_res.last));
        check_field("empty_res", ValW'(exp_res.empty), ValW'(act_res.empty));
        check_field("found_in_a", ValW'(exp_res.in_a), ValW'(act_res.in_a));
        check_field("found_in_b", ValW'(exp_res.in_b), ValW'(act_res.in_b));
        check_field("count_a", ValW'(exp_res.cnt_a), ValW'(act_res.cnt_a));
        check_field("count_b", ValW'(exp_res.cnt_b), ValW'(act_res.cnt_b));
        check_field("overflow", ValW'(exp_res.ovf), ValW'(act_res.ovf));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------
  initial begin
    build_stimulus();
    n_total = req_queue.size();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (req_queue.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    // Give any stray transfer a chance to show up.
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
